>>> design/ace_color_equalization_core_defines.svh
// Assertion macros for the colour equalization core checker.
// Needs signals named clk and rst in the module that uses them.
`ifndef ACE_COLOR_EQUALIZATION_CORE_DEFINES_SVH
`define ACE_COLOR_EQUALIZATION_CORE_DEFINES_SVH

// Property checked only outside reset.
`define ACE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ACE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ace_pkg.sv
// Shared constants, codes and control structures of the colour equalization core.
// No dependencies.
package ace_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COLOUR_BITS = 8;
  localparam int SCORE_BITS  = 18;
  localparam int SLOPE_BITS  = 16;
  localparam int LIMIT_BITS  = 24;
  localparam int MIND_BITS   = 13;
  localparam int CFG_BITS    = 24;
  localparam int IDX_BITS    = 2;
  localparam int SUM_BITS    = 48;
  localparam int TERM_BITS   = 32;
  localparam int RECIP_BITS  = 33;
  localparam int PROD_BITS   = RECIP_BITS + LIMIT_BITS;
  localparam int Q_BITS      = 16;
  localparam int DIV_STEPS   = 16;
  localparam int D2_BITS     = 2 * COORD_BITS + 1;
  localparam int RAD_BITS    = D2_BITS + 16;
  localparam int ROOT_ITER   = (RAD_BITS + 1) / 2;
  localparam int DIST_BITS   = ROOT_ITER;
  localparam int RECIP_STEPS = 33;
  localparam int STEP_BITS   = 6;
  localparam int NUM_BITS    = 27;

  localparam logic [SLOPE_BITS-1:0] SLOPE_RESET = 16'd2560;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 24'd256000;
  localparam logic [SCORE_BITS-1:0] MIN_RESET   = 18'h1FFFF;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_SCALE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_SLOPE    = 2'd0,
    REG_LIMIT    = 2'd1,
    REG_MIN_DIST = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ROOT, ST_CHECK, ST_RECIP,
    ST_MUL, ST_ACC, ST_DLOAD, ST_DIV, ST_EMIT
  } state_t;

  typedef struct packed {
    logic tgt_load;
    logic smp_load;
    logic scl_load;
    logic clr_ext;
    logic mul;
    logic acc;
    logic dload;
    logic dscale;
    logic dstep;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    logic tgt_load;
    logic smp_load;
    logic sq_load;
    logic root_step;
    logic recip_load;
    logic recip_step;
  } dist_ctrl_t;

endpackage

>>> design/ace_if.sv
// Handshake channels of the colour equalization core: input words and result words.
// Depends on ace_pkg.
interface ace_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              operation;
  logic [ace_pkg::COORD_BITS-1:0]          pos_x;
  logic [ace_pkg::COORD_BITS-1:0]          pos_y;
  logic [ace_pkg::COLOUR_BITS-1:0]         red;
  logic [ace_pkg::COLOUR_BITS-1:0]         green;
  logic [ace_pkg::COLOUR_BITS-1:0]         blue;
  logic                                    last_sample;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_in_red;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_in_green;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_in_blue;

  modport source (output valid, operation, pos_x, pos_y, red, green, blue, last_sample,
                  score_in_red, score_in_green, score_in_blue, input ready);
  modport sink (input valid, operation, pos_x, pos_y, red, green, blue, last_sample,
                score_in_red, score_in_green, score_in_blue, output ready);
endinterface

interface ace_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    result_kind;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_red;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_green;
  logic signed [ace_pkg::SCORE_BITS-1:0]   score_blue;
  logic [ace_pkg::COLOUR_BITS-1:0]         byte_red;
  logic [ace_pkg::COLOUR_BITS-1:0]         byte_green;
  logic [ace_pkg::COLOUR_BITS-1:0]         byte_blue;

  modport source (output valid, result_kind, score_red, score_green, score_blue,
                  byte_red, byte_green, byte_blue, input ready);
  modport sink (input valid, result_kind, score_red, score_green, score_blue,
                byte_red, byte_green, byte_blue, output ready);
endinterface

>>> design/ace_dist.sv
// Distance unit: squared distance, bit-pair square root and reciprocal by long division.
// Depends on ace_pkg.
module ace_dist (
  input  logic                             clk,
  input  logic                             rst,
  input  ace_pkg::dist_ctrl_t              ctrl,
  input  logic [ace_pkg::COORD_BITS-1:0]   pos_x,
  input  logic [ace_pkg::COORD_BITS-1:0]   pos_y,
  output logic                             d2_zero,
  output logic [ace_pkg::DIST_BITS-1:0]    distance,
  output logic [ace_pkg::RECIP_BITS-1:0]   recip
);

  logic [ace_pkg::COORD_BITS-1:0]   tx, ty, adx, ady;
  logic [ace_pkg::COORD_BITS-1:0]   dx_abs, dy_abs;
  logic [2*ace_pkg::COORD_BITS-1:0] sqx, sqy;
  logic [ace_pkg::D2_BITS-1:0]      d2;
  logic                             d2z;
  logic [ace_pkg::RAD_BITS-1:0]     rv, rbit;
  logic [ace_pkg::RAD_BITS:0]       rres, rsum;
  logic [ace_pkg::DIST_BITS-1:0]    rrem;
  logic [ace_pkg::DIST_BITS:0]      rem2;
  logic                             rge;
  logic [ace_pkg::RECIP_BITS-1:0]   rq;

  // Target coordinates live here; reset puts the target at the origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx <= '0;
      ty <= '0;
    end else if (ctrl.tgt_load) begin
      tx <= pos_x;
      ty <= pos_y;
    end
  end

  // Absolute coordinate differences and the squared distance.
  assign dx_abs = (tx >= pos_x) ? tx - pos_x : pos_x - tx;
  assign dy_abs = (ty >= pos_y) ? ty - pos_y : pos_y - ty;
  assign sqx    = adx * adx;
  assign sqy    = ady * ady;
  assign d2     = {1'b0, sqx} + {1'b0, sqy};

  // One bit pair of the root per cycle; one quotient bit of 2^40 / distance per cycle.
  assign rsum = rres + {1'b0, rbit};
  assign rem2 = {rrem, 1'b0};
  assign rge  = rem2 >= {1'b0, distance};

  always_ff @(posedge clk) begin
    if (ctrl.smp_load) begin
      adx <= dx_abs;
      ady <= dy_abs;
    end
    if (ctrl.sq_load) begin
      d2z  <= (d2 == '0);
      rv   <= {d2, 16'h0000};
      rres <= '0;
      rbit <= ace_pkg::RAD_BITS'(1) << (2 * (ace_pkg::ROOT_ITER - 1));
    end else if (ctrl.root_step) begin
      if ({1'b0, rv} >= rsum) begin
        rv   <= rv - rsum[ace_pkg::RAD_BITS-1:0];
        rres <= (rres >> 1) + {1'b0, rbit};
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (ctrl.recip_load) begin
      rrem <= ace_pkg::DIST_BITS'(128);
      rq   <= '0;
    end else if (ctrl.recip_step) begin
      rrem <= rge ? ace_pkg::DIST_BITS'(rem2 - {1'b0, distance}) : rem2[ace_pkg::DIST_BITS-1:0];
      rq   <= {rq[ace_pkg::RECIP_BITS-2:0], rge};
    end
  end

  assign d2_zero  = d2z;
  assign distance = rres[ace_pkg::DIST_BITS-1:0];
  assign recip    = rq;

endmodule

>>> design/ace_lane.sv
// One colour lane: weighted difference, saturating sum, score or byte division, extrema.
// Depends on ace_pkg.
module ace_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ace_pkg::lane_ctrl_t                    ctrl,
  input  logic [ace_pkg::COLOUR_BITS-1:0]        colour,
  input  logic [ace_pkg::SCORE_BITS-1:0]         score_in,
  input  logic [ace_pkg::SLOPE_BITS-1:0]         slope,
  input  logic [ace_pkg::LIMIT_BITS-1:0]         limit,
  input  logic [ace_pkg::RECIP_BITS-1:0]         recip,
  input  logic [ace_pkg::SUM_BITS-1:0]           weight,
  output logic [ace_pkg::SCORE_BITS-1:0]         score,
  output logic [ace_pkg::COLOUR_BITS-1:0]        byte_val
);

  logic [ace_pkg::COLOUR_BITS-1:0] tgt;
  logic [ace_pkg::COLOUR_BITS:0]   diff;
  logic [ace_pkg::COLOUR_BITS-1:0] adiff;
  logic [ace_pkg::LIMIT_BITS-1:0]  wprod, mag;
  logic                            neg;
  logic [ace_pkg::PROD_BITS-1:0]   full;
  logic [ace_pkg::TERM_BITS-1:0]   term;
  logic [ace_pkg::SUM_BITS-1:0]    sum, sum_abs;
  logic [ace_pkg::SUM_BITS:0]      sadd, tsig;
  logic [ace_pkg::SCORE_BITS-1:0]  smax, smin, sv;
  logic [ace_pkg::SCORE_BITS:0]    den, vdiff;
  logic [ace_pkg::NUM_BITS-1:0]    num, num_abs;
  logic [ace_pkg::SCORE_BITS-1:0]  den_abs;
  logic [ace_pkg::SUM_BITS-1:0]    rem, dvs;
  logic [ace_pkg::SUM_BITS:0]      drem2;
  logic                            dge;
  logic [ace_pkg::Q_BITS-1:0]      shin, q;
  logic                            res_zero, res_sat, res_neg;
  logic [ace_pkg::SCORE_BITS-2:0]  qs;
  logic [ace_pkg::SCORE_BITS-1:0]  score_val;

  // Clamped weighted colour difference of the sample.
  assign diff  = {1'b0, tgt} - {1'b0, colour};
  assign adiff = diff[ace_pkg::COLOUR_BITS] ? ace_pkg::COLOUR_BITS'(-diff)
                                            : diff[ace_pkg::COLOUR_BITS-1:0];
  assign wprod = adiff * slope;

  // Distance weighting and saturating accumulation.
  assign full = ace_pkg::PROD_BITS'(mag) * ace_pkg::PROD_BITS'(recip);
  assign tsig = neg ? -{17'h0, term} : {17'h0, term};
  assign sadd = {sum[ace_pkg::SUM_BITS-1], sum} + tsig;

  // Operands of the division for a score or for a scaled byte.
  assign sum_abs = sum[ace_pkg::SUM_BITS-1] ? -sum : sum;
  assign den     = {smax[ace_pkg::SCORE_BITS-1], smax} - {smin[ace_pkg::SCORE_BITS-1], smin};
  assign vdiff   = {sv[ace_pkg::SCORE_BITS-1], sv} - {smin[ace_pkg::SCORE_BITS-1], smin};
  assign num     = ({{8{vdiff[ace_pkg::SCORE_BITS]}}, vdiff} << 8)
                   - {{8{vdiff[ace_pkg::SCORE_BITS]}}, vdiff};
  assign num_abs = num[ace_pkg::NUM_BITS-1] ? -num : num;
  assign den_abs = den[ace_pkg::SCORE_BITS] ? ace_pkg::SCORE_BITS'(-den)
                                            : den[ace_pkg::SCORE_BITS-1:0];

  // Restoring division step.
  assign drem2 = {rem, shin[ace_pkg::Q_BITS-1]};
  assign dge   = drem2 >= {1'b0, dvs};

  // Final values after the division.
  assign qs        = res_sat ? 17'h10000 : {1'b0, q};
  assign score_val = res_zero ? '0 : (res_neg ? -{1'b0, qs} : {1'b0, qs});
  assign score     = score_val;
  assign byte_val  = res_zero ? '0 : (res_sat ? 8'hFF : q[ace_pkg::Q_BITS-1:8]);

  // Target colour, running sum and extrema.
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt  <= '0;
      sum  <= '0;
      smax <= '0;
      smin <= ace_pkg::MIN_RESET;
    end else begin
      if (ctrl.tgt_load) begin
        tgt <= colour;
        sum <= '0;
      end else if (ctrl.acc) begin
        if (sadd[ace_pkg::SUM_BITS] != sadd[ace_pkg::SUM_BITS-1]) begin
          sum <= {sadd[ace_pkg::SUM_BITS], {(ace_pkg::SUM_BITS-1){~sadd[ace_pkg::SUM_BITS]}}};
        end else begin
          sum <= sadd[ace_pkg::SUM_BITS-1:0];
        end
      end else if (ctrl.commit && !ctrl.dscale) begin
        sum <= '0;
      end
      if (ctrl.clr_ext) begin
        smax <= '0;
        smin <= ace_pkg::MIN_RESET;
      end else if (ctrl.commit && !ctrl.dscale) begin
        if ($signed(score_val) > $signed(smax)) smax <= score_val;
        if ($signed(score_val) < $signed(smin)) smin <= score_val;
      end
    end
  end

  // Datapath registers of the sample and of the divider.
  always_ff @(posedge clk) begin
    if (ctrl.smp_load) begin
      neg <= diff[ace_pkg::COLOUR_BITS];
      mag <= (wprod > limit) ? limit : wprod;
    end
    if (ctrl.scl_load) sv <= score_in;
    if (ctrl.mul) term <= full[24 +: ace_pkg::TERM_BITS];
    if (ctrl.dload) begin
      q <= '0;
      if (ctrl.dscale) begin
        res_zero <= (den == '0) || (num == '0)
                    || (num[ace_pkg::NUM_BITS-1] != den[ace_pkg::SCORE_BITS]);
        res_sat  <= num_abs[ace_pkg::NUM_BITS-2:8] >= den_abs;
        res_neg  <= 1'b0;
        rem      <= ace_pkg::SUM_BITS'(num_abs[ace_pkg::NUM_BITS-2:8]);
        dvs      <= ace_pkg::SUM_BITS'(den_abs);
        shin     <= {num_abs[7:0], 8'h00};
      end else begin
        res_zero <= (weight == '0);
        res_sat  <= sum_abs >= weight;
        res_neg  <= sum[ace_pkg::SUM_BITS-1];
        rem      <= sum_abs;
        dvs      <= weight;
        shin     <= '0;
      end
    end else if (ctrl.dstep) begin
      rem  <= dge ? ace_pkg::SUM_BITS'(drem2 - {1'b0, dvs}) : drem2[ace_pkg::SUM_BITS-1:0];
      shin <= shin << 1;
      q    <= {q[ace_pkg::Q_BITS-2:0], dge};
    end
  end

endmodule

>>> design/ace_color_equalization_core.sv
// Top level of the colour equalization core: sequencer, weight sum, lanes and result merge.
// Depends on ace_pkg, ace_if, ace_dist and ace_lane.
//
//  channel  | direction | handshake     | word
//  in_ch    | in        | valid/ready   | operation, position, colour, last flag, scores
//  out_ch   | out       | valid/ready   | result kind, three scores, three bytes
//  config   | in        | write_enable  | reg_index, write_data
//
// One word is worked on at a time; start and clear finish on acceptance. A sample is
// squared, rooted in ROOT_ITER steps and checked; a used sample adds 33 reciprocal
// steps, a multiply and an accumulate; a last sample adds the 16-step score division.
// Scale runs the same division; the distance root and reciprocal set the sample time.
// Reset is synchronous; a stalled result sits in the output register until taken.
module ace_color_equalization_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [ace_pkg::IDX_BITS-1:0]    reg_index,
  input  logic [ace_pkg::CFG_BITS-1:0]    write_data,
  ace_in_if.sink                          in_ch,
  ace_out_if.source                       out_ch
);

  ace_pkg::state_t                   state, state_next;
  ace_pkg::lane_ctrl_t               lctrl;
  ace_pkg::dist_ctrl_t               dctrl;
  logic [ace_pkg::STEP_BITS-1:0]     cnt;
  logic                              last, mode_scale, accept, commit, use_sample;
  logic [ace_pkg::SLOPE_BITS-1:0]    slope;
  logic [ace_pkg::LIMIT_BITS-1:0]    limit;
  logic [ace_pkg::MIND_BITS-1:0]     min_dist;
  logic                              d2_zero;
  logic [ace_pkg::DIST_BITS-1:0]     distance;
  logic [ace_pkg::RECIP_BITS-1:0]    recip;
  logic [ace_pkg::PROD_BITS-1:0]     wfull;
  logic [ace_pkg::TERM_BITS-1:0]     wt;
  logic [ace_pkg::SUM_BITS-1:0]      weight;
  logic [ace_pkg::SUM_BITS:0]        wadd;
  logic [ace_pkg::COLOUR_BITS-1:0]   colour_in [3];
  logic [ace_pkg::SCORE_BITS-1:0]    score_in  [3];
  logic [ace_pkg::SCORE_BITS-1:0]    lscore    [3];
  logic [ace_pkg::COLOUR_BITS-1:0]   lbyte     [3];
  logic                              ovalid, okind;
  logic [ace_pkg::SCORE_BITS-1:0]    oscore    [3];
  logic [ace_pkg::COLOUR_BITS-1:0]   obyte     [3];

  assign accept     = in_ch.valid && in_ch.ready;
  assign commit     = (state == ace_pkg::ST_EMIT) && (!ovalid || out_ch.ready);
  assign use_sample = !d2_zero && (32'(distance) >= 32'({min_dist, 8'h00}));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope    <= ace_pkg::SLOPE_RESET;
      limit    <= ace_pkg::LIMIT_RESET;
      min_dist <= '0;
    end else if (write_enable) begin
      case (reg_index)
        ace_pkg::REG_SLOPE:    slope    <= write_data[ace_pkg::SLOPE_BITS-1:0];
        ace_pkg::REG_LIMIT:    limit    <= write_data[ace_pkg::LIMIT_BITS-1:0];
        ace_pkg::REG_MIN_DIST: min_dist <= write_data[ace_pkg::MIND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, step counter and per-word flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ace_pkg::ST_IDLE;
      cnt        <= '0;
      last       <= 1'b0;
      mode_scale <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 1'b1;
      if (accept) begin
        last       <= in_ch.last_sample;
        mode_scale <= (in_ch.operation == ace_pkg::OP_SCALE);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ace_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.operation)
            ace_pkg::OP_SAMPLE: state_next = ace_pkg::ST_SQ;
            ace_pkg::OP_SCALE:  state_next = ace_pkg::ST_DLOAD;
            default:            state_next = ace_pkg::ST_IDLE;
          endcase
        end
      end
      ace_pkg::ST_SQ:    state_next = ace_pkg::ST_ROOT;
      ace_pkg::ST_ROOT: begin
        if (cnt == ace_pkg::STEP_BITS'(ace_pkg::ROOT_ITER - 1)) state_next = ace_pkg::ST_CHECK;
      end
      ace_pkg::ST_CHECK: begin
        if (use_sample)  state_next = ace_pkg::ST_RECIP;
        else if (last)   state_next = ace_pkg::ST_DLOAD;
        else             state_next = ace_pkg::ST_IDLE;
      end
      ace_pkg::ST_RECIP: begin
        if (cnt == ace_pkg::STEP_BITS'(ace_pkg::RECIP_STEPS - 1)) state_next = ace_pkg::ST_MUL;
      end
      ace_pkg::ST_MUL:   state_next = ace_pkg::ST_ACC;
      ace_pkg::ST_ACC:   state_next = last ? ace_pkg::ST_DLOAD : ace_pkg::ST_IDLE;
      ace_pkg::ST_DLOAD: state_next = ace_pkg::ST_DIV;
      ace_pkg::ST_DIV: begin
        if (cnt == ace_pkg::STEP_BITS'(ace_pkg::DIV_STEPS - 1)) state_next = ace_pkg::ST_EMIT;
      end
      ace_pkg::ST_EMIT: begin
        if (commit) state_next = ace_pkg::ST_IDLE;
      end
      default: state_next = ace_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    lctrl       = '0;
    dctrl       = '0;
    in_ch.ready = (state == ace_pkg::ST_IDLE);
    lctrl.dscale = mode_scale;
    case (state)
      ace_pkg::ST_IDLE: begin
        if (accept) begin
          lctrl.tgt_load = (in_ch.operation == ace_pkg::OP_START);
          dctrl.tgt_load = (in_ch.operation == ace_pkg::OP_START);
          lctrl.clr_ext  = (in_ch.operation == ace_pkg::OP_CLEAR);
          lctrl.smp_load = (in_ch.operation == ace_pkg::OP_SAMPLE);
          dctrl.smp_load = (in_ch.operation == ace_pkg::OP_SAMPLE);
          lctrl.scl_load = (in_ch.operation == ace_pkg::OP_SCALE);
        end
      end
      ace_pkg::ST_SQ:    dctrl.sq_load    = 1'b1;
      ace_pkg::ST_ROOT:  dctrl.root_step  = 1'b1;
      ace_pkg::ST_CHECK: dctrl.recip_load = use_sample;
      ace_pkg::ST_RECIP: dctrl.recip_step = 1'b1;
      ace_pkg::ST_MUL:   lctrl.mul        = 1'b1;
      ace_pkg::ST_ACC:   lctrl.acc        = 1'b1;
      ace_pkg::ST_DLOAD: lctrl.dload      = 1'b1;
      ace_pkg::ST_DIV:   lctrl.dstep      = 1'b1;
      ace_pkg::ST_EMIT:  lctrl.commit     = commit;
      default: ;
    endcase
  end

  // Distance unit.
  ace_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .pos_x    (in_ch.pos_x),
    .pos_y    (in_ch.pos_y),
    .d2_zero  (d2_zero),
    .distance (distance),
    .recip    (recip)
  );

  // Weight sum: limit over distance, saturating; cleared on start and after a pixel.
  assign wfull = ace_pkg::PROD_BITS'(limit) * ace_pkg::PROD_BITS'(recip);
  assign wadd  = {1'b0, weight} + (ace_pkg::SUM_BITS + 1)'(wt);

  always_ff @(posedge clk) begin
    if (lctrl.mul) wt <= wfull[24 +: ace_pkg::TERM_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (lctrl.tgt_load || (commit && !mode_scale)) begin
      weight <= '0;
    end else if (lctrl.acc) begin
      weight <= wadd[ace_pkg::SUM_BITS] ? '1 : wadd[ace_pkg::SUM_BITS-1:0];
    end
  end

  // Colour lanes.
  assign colour_in[0] = in_ch.red;
  assign colour_in[1] = in_ch.green;
  assign colour_in[2] = in_ch.blue;
  assign score_in[0]  = in_ch.score_in_red;
  assign score_in[1]  = in_ch.score_in_green;
  assign score_in[2]  = in_ch.score_in_blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    ace_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lctrl),
      .colour   (colour_in[c]),
      .score_in (score_in[c]),
      .slope    (slope),
      .limit    (limit),
      .recip    (recip),
      .weight   (weight),
      .score    (lscore[c]),
      .byte_val (lbyte[c])
    );
  end

  // Result merge into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (commit) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      okind <= mode_scale;
      for (int c = 0; c < 3; c++) begin
        oscore[c] <= mode_scale ? '0 : lscore[c];
        obyte[c]  <= mode_scale ? lbyte[c] : '0;
      end
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.result_kind = okind;
  assign out_ch.score_red   = oscore[0];
  assign out_ch.score_green = oscore[1];
  assign out_ch.score_blue  = oscore[2];
  assign out_ch.byte_red    = obyte[0];
  assign out_ch.byte_green  = obyte[1];
  assign out_ch.byte_blue   = obyte[2];

endmodule

>>> design/ace_checker.sv
// Port-level checks of the colour equalization core, bound to the top level.
// Depends on ace_pkg and ace_color_equalization_core_defines.svh.
`include "ace_color_equalization_core_defines.svh"

module ace_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  result_kind,
  input logic signed [ace_pkg::SCORE_BITS-1:0] score_red,
  input logic signed [ace_pkg::SCORE_BITS-1:0] score_green,
  input logic [ace_pkg::COLOUR_BITS-1:0]       byte_red,
  input logic [ace_pkg::COLOUR_BITS-1:0]       byte_blue
);

  // A word waiting at the output stays until taken.
  `ACE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // Reset empties the output register.
  `ACE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // Score words carry no bytes and scaled words carry no scores.
  `ACE_ASSERT(a_kind_fields, out_valid |-> (result_kind ? (score_red == 0 && score_green == 0) : (byte_red == 0 && byte_blue == 0)), "field not cleared for result kind")

  // The red score stays within plus and minus one.
  `ACE_ASSERT(a_score_range, out_valid |-> (score_red <= 18'sd65536 && score_red >= -18'sd65536), "score out of range")

endmodule

bind ace_color_equalization_core ace_checker u_ace_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_kind (out_ch.result_kind),
  .score_red   (out_ch.score_red),
  .score_green (out_ch.score_green),
  .byte_red    (out_ch.byte_red),
  .byte_blue   (out_ch.byte_blue)
);

>>> tb/ace_color_equalization_core_test.sv
// Self-checking testbench of the colour equalization core: directed and random words,
// checked against a behavioural predictor held in a small scoreboard class.
// Depends on ace_pkg, ace_if and ace_color_equalization_core.
module ace_color_equalization_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ace_pkg::*;

  typedef struct {
    op_t                           operation;
    logic [COORD_BITS-1:0]         pos_x;
    logic [COORD_BITS-1:0]         pos_y;
    logic [COLOUR_BITS-1:0]        rgb [3];
    logic                          last_sample;
    logic signed [SCORE_BITS-1:0]  score_in [3];
  } pixel_word_t;

  typedef struct {
    logic                          result_kind;
    logic signed [SCORE_BITS-1:0]  score [3];
    logic [COLOUR_BITS-1:0]        byte_val [3];
  } result_word_t;

  // Behavioural model of the kernel and the queue of results it foresees.
  class equalizer_scoreboard;
    localparam longint SUM_LIMIT = 64'sh7FFF_FFFF_FFFF;
    localparam longint unsigned WEIGHT_LIMIT = 64'hFFFF_FFFF_FFFF;

    longint unsigned slope_q, limit_q, min_dist_q;
    int unsigned tgt_x, tgt_y;
    int tgt_rgb [3];
    longint col_sum [3];
    longint unsigned weight_acc;
    int hi_score [3];
    int lo_score [3];
    result_word_t pending_q [$];
    int errors;

    function new();
      slope_q = SLOPE_RESET;
      limit_q = LIMIT_RESET;
      min_dist_q = 0;
      tgt_x = 0;
      tgt_y = 0;
      weight_acc = 0;
      errors = 0;
      for (int c = 0; c < 3; c++) begin
        tgt_rgb[c] = 0;
        col_sum[c] = 0;
        hi_score[c] = 0;
        lo_score[c] = 131071;
      end
    endfunction

    function void set_register(reg_idx_t idx, logic [CFG_BITS-1:0] value);
      case (idx)
        REG_SLOPE: slope_q = value[SLOPE_BITS-1:0];
        REG_LIMIT: limit_q = value[LIMIT_BITS-1:0];
        REG_MIN_DIST: min_dist_q = value[MIND_BITS-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return int_sqrt_done(root);
    endfunction

    function longint unsigned int_sqrt_done(longint unsigned r);
      return r;
    endfunction

    function int score_quotient(longint s, longint unsigned w);
      longint unsigned mag, q;
      if (w == 0) return 0;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      if (mag >= w) q = 65536;
      else q = (mag << 16) / w;
      if (q > 65536) q = 65536;
      return (s < 0) ? -int'(q) : int'(q);
    endfunction

    function logic [7:0] scale_to_byte(int v, int hi, int lo);
      longint den, num, r;
      den = longint'(hi) - longint'(lo);
      if (den == 0) return 8'd0;
      num = (longint'(v) - longint'(lo)) * 255;
      r = num / den;
      if (r < 0) r = 0;
      if (r > 255) r = 255;
      return r[7:0];
    endfunction

    function void clear_sums();
      for (int c = 0; c < 3; c++) col_sum[c] = 0;
      weight_acc = 0;
    endfunction

    // Update the state for an accepted input word and queue any result it causes.
    function void note_input(pixel_word_t w);
      longint dx, dy, diff, term, s;
      longint unsigned d2, root_dist, recip, wt, mag;
      result_word_t r;
      int sc;
      case (w.operation)
        OP_START: begin
          tgt_x = w.pos_x;
          tgt_y = w.pos_y;
          for (int c = 0; c < 3; c++) tgt_rgb[c] = w.rgb[c];
          clear_sums();
        end
        OP_SAMPLE: begin
          dx = longint'(tgt_x) - longint'(w.pos_x);
          dy = longint'(tgt_y) - longint'(w.pos_y);
          d2 = dx * dx + dy * dy;
          root_dist = int_sqrt(d2 << 16);
          if (d2 != 0 && root_dist >= (min_dist_q << 8)) begin
            recip = (64'd1 << 40) / root_dist;
            wt = (limit_q * recip) >> 24;
            for (int c = 0; c < 3; c++) begin
              diff = tgt_rgb[c] - int'(w.rgb[c]);
              mag = ((diff < 0) ? -diff : diff) * slope_q;
              if (mag > limit_q) mag = limit_q;
              term = (mag * recip) >> 24;
              s = col_sum[c] + ((diff < 0) ? -term : term);
              if (s > SUM_LIMIT) s = SUM_LIMIT;
              if (s < -SUM_LIMIT - 1) s = -SUM_LIMIT - 1;
              col_sum[c] = s;
            end
            weight_acc += wt;
            if (weight_acc > WEIGHT_LIMIT) weight_acc = WEIGHT_LIMIT;
          end
          if (w.last_sample) begin
            r.result_kind = 1'b0;
            for (int c = 0; c < 3; c++) begin
              sc = score_quotient(col_sum[c], weight_acc);
              if (sc > hi_score[c]) hi_score[c] = sc;
              if (sc < lo_score[c]) lo_score[c] = sc;
              r.score[c] = sc[SCORE_BITS-1:0];
              r.byte_val[c] = '0;
            end
            clear_sums();
            pending_q.push_back(r);
          end
        end
        OP_SCALE: begin
          r.result_kind = 1'b1;
          for (int c = 0; c < 3; c++) begin
            r.score[c] = '0;
            r.byte_val[c] = scale_to_byte(int'(w.score_in[c]), hi_score[c], lo_score[c]);
          end
          pending_q.push_back(r);
        end
        default: begin
          for (int c = 0; c < 3; c++) begin
            hi_score[c] = 0;
            lo_score[c] = 131071;
          end
        end
      endcase
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Compare one delivered result word with the oldest one foreseen.
    task check_result(result_word_t got);
      result_word_t exp_w;
      if (pending_q.size() == 0) begin
        report("result word with nothing outstanding");
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.result_kind !== exp_w.result_kind)
        report($sformatf("result_kind %0d, expected %0d", got.result_kind,
                         exp_w.result_kind));
      for (int c = 0; c < 3; c++) begin
        if (got.score[c] !== exp_w.score[c])
          report($sformatf("score of colour %0d is %0d, expected %0d", c, got.score[c],
                           exp_w.score[c]));
        if (got.byte_val[c] !== exp_w.byte_val[c])
          report($sformatf("byte of colour %0d is %0d, expected %0d", c, got.byte_val[c],
                           exp_w.byte_val[c]));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic write_enable;
  logic [IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0] write_data;

  ace_in_if in_ch ();
  ace_out_if out_ch ();

  ace_color_equalization_core dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  equalizer_scoreboard board = new();
  int burst_left = 0;
  int results_seen = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Collect each delivered result word and check it.
  always @(posedge clk) begin
    result_word_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.result_kind = out_ch.result_kind;
      got.score[0] = out_ch.score_red;
      got.score[1] = out_ch.score_green;
      got.score[2] = out_ch.score_blue;
      got.byte_val[0] = out_ch.byte_red;
      got.byte_val[1] = out_ch.byte_green;
      got.byte_val[2] = out_ch.byte_blue;
      board.check_result(got);
      results_seen++;
    end
  end

  // Receiver back-pressure: stretches of steady readiness, random stalls and one long hold.
  initial begin
    int mode_left;
    int mode;
    bit held;
    out_ch.ready <= 1'b0;
    mode_left = 0;
    mode = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 40) begin
        held = 1;
        out_ch.ready <= 1'b0;
        repeat (500) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one word and wait until it is taken; the sender works in bursts with gaps.
  task automatic send_word(pixel_word_t w);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= w.operation;
    in_ch.pos_x <= w.pos_x;
    in_ch.pos_y <= w.pos_y;
    in_ch.red <= w.rgb[0];
    in_ch.green <= w.rgb[1];
    in_ch.blue <= w.rgb[2];
    in_ch.last_sample <= w.last_sample;
    in_ch.score_in_red <= w.score_in[0];
    in_ch.score_in_green <= w.score_in[1];
    in_ch.score_in_blue <= w.score_in[2];
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(w);
  endtask

  function automatic pixel_word_t make_word(op_t op, int x, int y, int r, int g, int b,
                                            bit last);
    pixel_word_t w;
    w.operation = op;
    w.pos_x = x;
    w.pos_y = y;
    w.rgb[0] = r;
    w.rgb[1] = g;
    w.rgb[2] = b;
    w.last_sample = last;
    for (int c = 0; c < 3; c++) w.score_in[c] = $urandom;
    return w;
  endfunction

  function automatic pixel_word_t scale_word(int sr, int sg, int sb);
    pixel_word_t w;
    w = make_word(OP_SCALE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    w.score_in[0] = sr;
    w.score_in[1] = sg;
    w.score_in[2] = sb;
    return w;
  endfunction

  task automatic write_register(reg_idx_t idx, logic [CFG_BITS-1:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    @(posedge clk);
    write_enable <= 1'b0;
    board.set_register(idx, value);
  endtask

  // Let the core drain: all results in, then room for a word that yields none.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic int random_score();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 65536 : -65536;
      default: return int'($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  // Random part: mostly whole pixels (start, samples, last), some scaling and noise.
  task automatic random_words(int count);
    pixel_word_t w;
    int sent;
    int n;
    int tx, ty, x, y;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 99)) inside
        [0:74]: begin
          tx = $urandom_range(0, 4095);
          ty = $urandom_range(0, 4095);
          send_word(make_word(OP_START, tx, ty, $urandom, $urandom, $urandom, $urandom));
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
              0: begin x = tx; y = ty; end
              1, 2: begin
                x = (tx + int'($urandom_range(0, 16)) - 8) & 12'hFFF;
                y = (ty + int'($urandom_range(0, 16)) - 8) & 12'hFFF;
              end
              default: begin x = $urandom_range(0, 4095); y = $urandom_range(0, 4095); end
            endcase
            send_word(make_word(OP_SAMPLE, x, y, $urandom, $urandom, $urandom, i == n - 1));
          end
          sent += n + 1;
        end
        [75:89]: begin
          send_word(scale_word(random_score(), random_score(), random_score()));
          sent++;
        end
        [90:92]: begin
          send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom));
          sent++;
        end
        default: begin
          w = make_word(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
          send_word(w);
          sent++;
        end
      endcase
    end
  endtask

  // Main sequence: reset, directed words, then random phases over several settings.
  initial begin
    rst <= 1'b1;
    write_enable <= 1'b0;
    reg_index <= '0;
    write_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_START;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.red <= '0;
    in_ch.green <= '0;
    in_ch.blue <= '0;
    in_ch.last_sample <= 1'b0;
    in_ch.score_in_red <= '0;
    in_ch.score_in_green <= '0;
    in_ch.score_in_blue <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: sample on the target is skipped, far corner, zero weight, equal extrema.
    send_word(make_word(OP_SAMPLE, 5, 5, 10, 20, 30, 1));
    send_word(make_word(OP_START, 0, 0, 255, 0, 128, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 255, 128, 0));
    send_word(make_word(OP_SAMPLE, 4095, 4095, 0, 255, 128, 1));
    send_word(make_word(OP_START, 4095, 0, 0, 255, 255, 0));
    send_word(make_word(OP_SAMPLE, 0, 4095, 255, 0, 0, 0));
    send_word(make_word(OP_SAMPLE, 4094, 1, 255, 255, 0, 1));
    send_word(scale_word(-65536, 65536, 0));
    send_word(scale_word(-131072, 131071, 1));
    send_word(make_word(OP_CLEAR, 4095, 4095, 255, 255, 255, 1));
    send_word(scale_word(0, 65536, -65536));
    send_word(make_word(OP_START, 100, 200, 7, 7, 7, 1));
    send_word(make_word(OP_SAMPLE, 100, 200, 0, 0, 0, 1));
    send_word(scale_word(0, 5, -5));
    send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(make_word(OP_START, 2048, 2048, 128, 128, 128, 0));
    send_word(make_word(OP_SAMPLE, 2049, 2048, 128, 128, 128, 0));
    send_word(make_word(OP_SAMPLE, 0, 0, 0, 255, 127, 1));
    send_word(scale_word(65536, -65536, 131071));
    random_words(180);
    drain();

    // Low extremes of every register.
    write_register(REG_SLOPE, 0);
    write_register(REG_LIMIT, 1);
    write_register(REG_MIN_DIST, 0);
    random_words(180);
    drain();

    // High extremes: only far samples count.
    write_register(REG_SLOPE, 16'hFFFF);
    write_register(REG_LIMIT, 24'hFF_FFFF);
    write_register(REG_MIN_DIST, 4096);
    random_words(180);
    drain();

    // Random settings with a small minimum distance.
    write_register(REG_SLOPE, $urandom_range(0, 65535));
    write_register(REG_LIMIT, $urandom_range(1, 16777215));
    write_register(REG_MIN_DIST, $urandom_range(0, 40));
    random_words(180);
    drain();

    // Random settings over wide ranges, minimum distance up to 4096.
    write_register(REG_SLOPE, $urandom_range(0, 65535));
    write_register(REG_LIMIT, $urandom_range(1, 16777215));
    write_register(REG_MIN_DIST, $urandom_range(0, 4096));
    random_words(180);
    drain();

    if (board.pending_q.size() != 0) board.report("results still outstanding at the end");
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> ace_color_equalization_core.f
+incdir+design
design/ace_pkg.sv
design/ace_if.sv
design/ace_dist.sv
design/ace_lane.sv
design/ace_color_equalization_core.sv
design/ace_checker.sv
tb/ace_color_equalization_core_test.sv
